[rtl/fts_pkg.sv]
// ----------------------------------------------------------------------------
// fts_pkg
// Types and constants shared by the floppy transfer sequencer files.
// ----------------------------------------------------------------------------
package fts_pkg;

    // Action codes carried by each result transaction.
    typedef enum logic [3:0] {
        ACT_MOTOR_ON  = 4'd0,
        ACT_MOTOR_OFF = 4'd1,
        ACT_RESET     = 4'd2,
        ACT_RECAL     = 4'd3,
        ACT_SEEK      = 4'd4,
        ACT_XFER      = 4'd5,
        ACT_ARM       = 4'd6,
        ACT_CANCEL    = 4'd7,
        ACT_DONE      = 4'd8,
        ACT_FAILED    = 4'd9,
        ACT_DECONF    = 4'd10
    } t_act;

    // Drive state.
    typedef enum logic [3:0] {
        DRV_CLOSED      = 4'd0,
        DRV_SPINUP      = 4'd1,
        DRV_RESET       = 4'd2,
        DRV_RECAL       = 4'd3,
        DRV_SEEK        = 4'd4,
        DRV_SETTLE      = 4'd5,
        DRV_XFER        = 4'd6,
        DRV_READY       = 4'd7,
        DRV_OFF         = 4'd8,
        DRV_ABSENT      = 4'd9,
        DRV_SPINUP_WARM = 4'd10
    } t_drv;

    // Sequencer state of the top level.
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_DIV_END,
        SEQ_WAIT_END,
        SEQ_DIV_BLK,
        SEQ_WAIT_BLK,
        SEQ_EXEC,
        SEQ_EMIT
    } t_seq;

    // Event kinds.
    localparam logic [1:0] KIND_WORK  = 2'd0;
    localparam logic [1:0] KIND_TIMER = 2'd1;
    localparam logic [1:0] KIND_IRQ   = 2'd2;
    localparam logic [1:0] KIND_CLOSE = 2'd3;

    // Register indexes.
    localparam logic [2:0] REG_SPT     = 3'd0;
    localparam logic [2:0] REG_GAP     = 3'd1;
    localparam logic [2:0] REG_MAXERR  = 3'd2;
    localparam logic [2:0] REG_SPINUP  = 3'd3;
    localparam logic [2:0] REG_SETTLE  = 3'd4;
    localparam logic [2:0] REG_DRIVE   = 3'd5;

    // Fixed constants of the controller protocol.
    localparam logic [7:0]  ST0_ERR_MASK = 8'hF8;
    localparam logic [15:0] T_RECAL_MS   = 16'd4000;
    localparam logic [15:0] T_SEEK_MS    = 16'd5000;
    localparam logic [15:0] T_RESET_MS   = 16'd2000;
    localparam logic [15:0] T_IDLE_MS    = 16'd3000;
    localparam logic [7:0]  GAP_DEFAULT  = 8'h1B;
    localparam logic [17:0] BYTES_MAX    = 18'h3FFFF;

    // One result item without its last flag.
    typedef struct packed {
        logic [17:0] bytes_done;
        logic [15:0] timer_ms;
        logic        write_op;
        logic [5:0]  sector;
        logic        head;
        logic [7:0]  cylinder;
        t_act        action;
    } t_res;

    // Builds one result item.
    function automatic t_res mk_res(input t_act act, input logic [7:0] cyl,
                                    input logic hd, input logic [5:0] sec,
                                    input logic wr, input logic [15:0] ms,
                                    input logic [17:0] bytes);
        t_res r;
        r.action     = act;
        r.cylinder   = cyl;
        r.head       = hd;
        r.sector     = sec;
        r.write_op   = wr;
        r.timer_ms   = ms;
        r.bytes_done = bytes;
        return r;
    endfunction

endpackage

[rtl/fts_div.sv]
// ----------------------------------------------------------------------------
// fts_div
// Restoring divider, one quotient bit per cycle, for block / sectors per track.
// ----------------------------------------------------------------------------
module fts_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [11:0] i_dividend,
    input  logic [5:0]  i_divisor,
    output logic        o_done,
    output logic [11:0] o_quot,
    output logic [5:0]  o_rem
);

    logic        r_busy;
    logic [3:0]  r_cnt;
    logic [5:0]  r_div;
    logic [5:0]  r_rem;
    logic [11:0] r_quot;
    logic        r_done;
    logic [6:0]  w_sh;
    logic        w_ge;
    logic [6:0]  w_diff;

    // One trial subtraction per cycle.
    assign w_sh   = {r_rem, r_quot[11]};
    assign w_ge   = (w_sh >= {1'b0, r_div});
    assign w_diff = w_sh - {1'b0, r_div};

    // Control: run twelve steps after a start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 4'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd11) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= (i_divisor == 6'd0) ? 6'd1 : i_divisor;
            r_rem  <= 6'd0;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[5:0] : w_sh[5:0];
            r_quot <= {r_quot[10:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

[rtl/floppy_transfer_sequencer_top.sv]
// ----------------------------------------------------------------------------
// floppy_transfer_sequencer_top
// Event-driven sequencer for one floppy drive with an APB register port.
// ----------------------------------------------------------------------------
// The block takes one event at a time and is not ready again until every
// action it caused has been taken. The shared bit-serial divider produces
// one quotient bit per cycle; it runs once for the last block of a work
// request and, for every event, once for the block that the event needs.
module floppy_transfer_sequencer_top #(
    parameter int SECTOR_BYTES = 512,
    parameter int MAX_SECTORS  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Event channel.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: start_block[11:0], sector_count[20:12], is_write[21], status0[29:22]
    input  logic [31:0] i_s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    // Action channel.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: action[3:0], cylinder[11:4], head[12], sector[18:13],
    //        write_op[19], timer_ms[35:20], bytes_done[53:36]
    output logic [55:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // Register port.
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int PROD_W = 9 + $clog2(SECTOR_BYTES + 1);

    // Configuration registers.
    logic [5:0]  r_spt;
    logic [7:0]  r_gap;
    logic [7:0]  r_maxerr;
    logic [15:0] r_spinup;
    logic [15:0] r_settle;
    logic [1:0]  r_drive;
    logic        w_cfg_wr;
    logic [2:0]  w_reg;

    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel & i_penable & i_pwrite;
    assign w_reg    = i_paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt    <= 6'd18;
            r_gap    <= fts_pkg::GAP_DEFAULT;
            r_maxerr <= 8'd4;
            r_spinup <= 16'd1000;
            r_settle <= 16'd25;
            r_drive  <= 2'd0;
        end else if (w_cfg_wr) begin
            case (w_reg)
                fts_pkg::REG_SPT:    r_spt    <= i_pwdata[5:0];
                fts_pkg::REG_GAP:    r_gap    <= i_pwdata[7:0];
                fts_pkg::REG_MAXERR: r_maxerr <= i_pwdata[7:0];
                fts_pkg::REG_SPINUP: r_spinup <= i_pwdata[15:0];
                fts_pkg::REG_SETTLE: r_settle <= i_pwdata[15:0];
                fts_pkg::REG_DRIVE:  r_drive  <= i_pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (w_reg)
            fts_pkg::REG_SPT:    o_prdata = {26'd0, r_spt};
            fts_pkg::REG_GAP:    o_prdata = {24'd0, r_gap};
            fts_pkg::REG_MAXERR: o_prdata = {24'd0, r_maxerr};
            fts_pkg::REG_SPINUP: o_prdata = {16'd0, r_spinup};
            fts_pkg::REG_SETTLE: o_prdata = {16'd0, r_settle};
            fts_pkg::REG_DRIVE:  o_prdata = {30'd0, r_drive};
            default:             o_prdata = 32'd0;
        endcase
    end

    // Latched event.
    logic [1:0]  r_kind;
    logic [11:0] r_start;
    logic [8:0]  r_count;
    logic        r_iswr;
    logic [7:0]  r_st0;
    logic [12:0] r_end;
    logic [11:0] r_qend;

    // Drive state.
    fts_pkg::t_drv r_dst, n_dst;
    logic [7:0]  r_armcyl, n_armcyl;
    logic        r_known, n_known;
    logic [7:0]  r_err, n_err;
    logic        r_active, n_active;
    logic [11:0] r_cur, n_cur;
    logic [8:0]  r_left, n_left;
    logic [8:0]  r_done, n_done;
    logic        r_reqwr, n_reqwr;
    logic        r_motor, n_motor;

    // Result queue.
    fts_pkg::t_res r_res [4];
    fts_pkg::t_res n_res [4];
    logic [2:0]  r_cnt, n_cnt;
    logic [1:0]  r_idx;

    // Sequencer.
    fts_pkg::t_seq r_seq, n_seq;
    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_out_last;
    logic        w_div_start;
    logic [11:0] w_div_arg;
    logic        w_div_done;
    logic [11:0] w_quot;
    logic [5:0]  w_rem;
    logic        w_xfer_ok;
    logic [11:0] w_blk;

    assign w_in_acc   = i_s_axis_tvalid & o_s_axis_tready;
    assign w_out_acc  = o_m_axis_tvalid & i_m_axis_tready;
    assign w_out_last = ({1'b0, r_idx} == (r_cnt - 3'd1));

    // Block whose geometry the event needs.
    assign w_xfer_ok = (r_kind == fts_pkg::KIND_IRQ) && r_active &&
                       (r_dst == fts_pkg::DRV_XFER) &&
                       ((r_st0 & fts_pkg::ST0_ERR_MASK) == 8'd0);
    always_comb begin
        if (r_kind == fts_pkg::KIND_WORK) begin
            w_blk = r_start;
        end else if (w_xfer_ok) begin
            w_blk = r_cur + 12'd1;
        end else begin
            w_blk = r_cur;
        end
    end

    fts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_arg),
        .i_divisor  (r_spt),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Sequencer next state.
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            fts_pkg::SEQ_IDLE: begin
                if (w_in_acc) begin
                    n_seq = (i_s_axis_tuser == fts_pkg::KIND_WORK) ?
                            fts_pkg::SEQ_DIV_END : fts_pkg::SEQ_DIV_BLK;
                end
            end
            fts_pkg::SEQ_DIV_END:  n_seq = fts_pkg::SEQ_WAIT_END;
            fts_pkg::SEQ_WAIT_END: if (w_div_done) n_seq = fts_pkg::SEQ_DIV_BLK;
            fts_pkg::SEQ_DIV_BLK:  n_seq = fts_pkg::SEQ_WAIT_BLK;
            fts_pkg::SEQ_WAIT_BLK: if (w_div_done) n_seq = fts_pkg::SEQ_EXEC;
            fts_pkg::SEQ_EXEC: begin
                n_seq = (n_cnt == 3'd0) ? fts_pkg::SEQ_IDLE : fts_pkg::SEQ_EMIT;
            end
            fts_pkg::SEQ_EMIT: begin
                if (w_out_acc && w_out_last) n_seq = fts_pkg::SEQ_IDLE;
            end
            default: n_seq = fts_pkg::SEQ_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_s_axis_tready = (r_seq == fts_pkg::SEQ_IDLE);
        o_m_axis_tvalid = (r_seq == fts_pkg::SEQ_EMIT);
        w_div_start     = (r_seq == fts_pkg::SEQ_DIV_END) ||
                          (r_seq == fts_pkg::SEQ_DIV_BLK);
        w_div_arg       = (r_seq == fts_pkg::SEQ_DIV_END) ? r_end[11:0] : w_blk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= fts_pkg::SEQ_IDLE;
            r_idx <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_seq <= n_seq;
            if (r_seq == fts_pkg::SEQ_EXEC) begin
                r_cnt <= n_cnt;
                r_idx <= 2'd0;
            end else if (w_out_acc) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Event capture and the quotient of the last block.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind  <= i_s_axis_tuser;
            r_start <= i_s_axis_tdata[11:0];
            r_count <= i_s_axis_tdata[20:12];
            r_iswr  <= i_s_axis_tdata[21];
            r_st0   <= i_s_axis_tdata[29:22];
            r_end   <= {1'b0, i_s_axis_tdata[11:0]} +
                       {4'd0, i_s_axis_tdata[20:12]} - 13'd1;
        end
        if (r_seq == fts_pkg::SEQ_WAIT_END && w_div_done) begin
            r_qend <= w_quot;
        end
    end

    // Geometry of the selected block.
    logic [7:0] w_cyl;
    logic       w_head;
    logic [5:0] w_sec;
    assign w_cyl  = (w_quot[11:9] != 3'd0) ? 8'hFF : w_quot[8:1];
    assign w_head = w_quot[0];
    assign w_sec  = w_rem + 6'd1;

    // Event handling: next drive state and the list of actions.
    always_comb begin
        logic [2:0]        cnt;
        logic              do_seek;
        logic              do_xfer;
        logic              bad;
        logic [PROD_W-1:0] prod;
        logic [17:0]       bytes;

        n_dst    = r_dst;
        n_armcyl = r_armcyl;
        n_known  = r_known;
        n_err    = r_err;
        n_active = r_active;
        n_cur    = r_cur;
        n_left   = r_left;
        n_done   = r_done;
        n_reqwr  = r_reqwr;
        n_motor  = r_motor;
        for (int k = 0; k < 4; k++) begin
            n_res[k] = r_res[k];
        end
        cnt     = 3'd0;
        do_seek = 1'b0;
        do_xfer = 1'b0;
        bad     = (r_dst == fts_pkg::DRV_ABSENT) || (r_count == 9'd0) ||
                  ({1'b0, r_count} > 10'(MAX_SECTORS)) || r_end[12] ||
                  (r_qend[11:9] != 3'd0);
        prod    = PROD_W'(r_done + 9'd1) * PROD_W'(SECTOR_BYTES);
        bytes   = (32'(prod) > 32'(fts_pkg::BYTES_MAX)) ? fts_pkg::BYTES_MAX :
                  18'(prod);

        if (r_kind == fts_pkg::KIND_WORK) begin
            // New request.
            if (!r_active) begin
                if (bad) begin
                    n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_FAILED,
                        8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                    cnt = cnt + 3'd1;
                end else begin
                    n_active = 1'b1;
                    n_cur    = r_start;
                    n_left   = r_count;
                    n_done   = 9'd0;
                    n_reqwr  = r_iswr;
                    if (r_dst == fts_pkg::DRV_READY) begin
                        do_seek = 1'b1;
                    end else begin
                        n_motor = 1'b1;
                        n_dst   = (r_dst == fts_pkg::DRV_OFF) ?
                                  fts_pkg::DRV_SPINUP_WARM : fts_pkg::DRV_SPINUP;
                        n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_MOTOR_ON,
                            8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                        cnt = cnt + 3'd1;
                        n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_ARM,
                            8'd0, 1'b0, 6'd0, 1'b0, r_spinup, 18'd0);
                        cnt = cnt + 3'd1;
                    end
                end
            end
        end else if (r_kind == fts_pkg::KIND_CLOSE) begin
            // Close.
            if (r_active) begin
                n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_CANCEL,
                    8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                cnt = cnt + 3'd1;
                n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_FAILED,
                    8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                cnt = cnt + 3'd1;
                n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_MOTOR_OFF,
                    8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                cnt = cnt + 3'd1;
                n_active = 1'b0;
                n_motor  = 1'b0;
                n_dst    = fts_pkg::DRV_CLOSED;
            end else if (r_dst != fts_pkg::DRV_ABSENT) begin
                n_dst = fts_pkg::DRV_CLOSED;
                if (r_motor) begin
                    n_motor = 1'b0;
                    n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_MOTOR_OFF,
                        8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                    cnt = cnt + 3'd1;
                end
            end
        end else if (!r_active) begin
            // Idle timer stops the motor.
            if (r_kind == fts_pkg::KIND_TIMER && r_motor) begin
                n_motor = 1'b0;
                n_dst   = fts_pkg::DRV_OFF;
                n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_MOTOR_OFF,
                    8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                cnt = cnt + 3'd1;
            end
        end else if (r_kind == fts_pkg::KIND_TIMER) begin
            // Timer expiry during a request.
            case (r_dst)
                fts_pkg::DRV_SPINUP, fts_pkg::DRV_SEEK, fts_pkg::DRV_XFER: begin
                    if (r_dst == fts_pkg::DRV_XFER && r_err != 8'hFF) begin
                        n_err = r_err + 8'd1;
                    end
                    n_dst = fts_pkg::DRV_RESET;
                    n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_RESET,
                        8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                    cnt = cnt + 3'd1;
                    n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_ARM,
                        8'd0, 1'b0, 6'd0, 1'b0, fts_pkg::T_RESET_MS, 18'd0);
                    cnt = cnt + 3'd1;
                end
                fts_pkg::DRV_RESET: begin
                    n_dst    = fts_pkg::DRV_ABSENT;
                    n_motor  = 1'b0;
                    n_active = 1'b0;
                    n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_MOTOR_OFF,
                        8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                    cnt = cnt + 3'd1;
                    n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_DECONF,
                        8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                    cnt = cnt + 3'd1;
                    n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_FAILED,
                        8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                    cnt = cnt + 3'd1;
                end
                fts_pkg::DRV_RECAL: begin
                    n_motor  = 1'b0;
                    n_dst    = fts_pkg::DRV_CLOSED;
                    n_active = 1'b0;
                    n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_MOTOR_OFF,
                        8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                    cnt = cnt + 3'd1;
                    n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_FAILED,
                        8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                    cnt = cnt + 3'd1;
                end
                fts_pkg::DRV_SETTLE:      do_xfer = 1'b1;
                fts_pkg::DRV_SPINUP_WARM: do_seek = 1'b1;
                default: ;
            endcase
        end else begin
            // Controller interrupt during a request.
            case (r_dst)
                fts_pkg::DRV_RESET: begin
                    n_known = 1'b0;
                    n_dst   = fts_pkg::DRV_RECAL;
                    n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_RECAL,
                        8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                    cnt = cnt + 3'd1;
                    n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_ARM,
                        8'd0, 1'b0, 6'd0, 1'b0, fts_pkg::T_RECAL_MS, 18'd0);
                    cnt = cnt + 3'd1;
                end
                fts_pkg::DRV_RECAL: do_seek = 1'b1;
                fts_pkg::DRV_SEEK: begin
                    n_dst = fts_pkg::DRV_SETTLE;
                    n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_ARM,
                        8'd0, 1'b0, 6'd0, 1'b0, r_settle, 18'd0);
                    cnt = cnt + 3'd1;
                end
                fts_pkg::DRV_XFER: begin
                    n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_CANCEL,
                        8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                    cnt = cnt + 3'd1;
                    if (!w_xfer_ok) begin
                        // Transfer error: count it and recalibrate.
                        if (r_err != 8'hFF) begin
                            n_err = r_err + 8'd1;
                        end
                        n_known = 1'b0;
                        n_dst   = fts_pkg::DRV_RECAL;
                        n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_RECAL,
                            8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                        cnt = cnt + 3'd1;
                        n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_ARM,
                            8'd0, 1'b0, 6'd0, 1'b0, fts_pkg::T_RECAL_MS, 18'd0);
                        cnt = cnt + 3'd1;
                    end else begin
                        n_err  = 8'd0;
                        n_done = r_done + 9'd1;
                        n_cur  = r_cur + 12'd1;
                        n_left = (r_left != 9'd0) ? r_left - 9'd1 : 9'd0;
                        if (n_left != 9'd0) begin
                            do_xfer = 1'b1;
                        end else begin
                            n_active = 1'b0;
                            n_dst    = fts_pkg::DRV_READY;
                            n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_DONE,
                                8'd0, 1'b0, 6'd0, 1'b0, 16'd0, bytes);
                            cnt = cnt + 3'd1;
                            n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_ARM,
                                8'd0, 1'b0, 6'd0, 1'b0, fts_pkg::T_IDLE_MS, 18'd0);
                            cnt = cnt + 3'd1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // Seek or transfer at once; give up once errors pass the limit.
        if (do_seek) begin
            if (n_err > r_maxerr) begin
                n_err    = 8'd0;
                n_motor  = 1'b0;
                n_dst    = fts_pkg::DRV_CLOSED;
                n_active = 1'b0;
                n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_MOTOR_OFF,
                    8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                cnt = cnt + 3'd1;
                n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_FAILED,
                    8'd0, 1'b0, 6'd0, 1'b0, 16'd0, 18'd0);
                cnt = cnt + 3'd1;
            end else if (n_known && n_armcyl == w_cyl) begin
                do_xfer = 1'b1;
            end else begin
                n_armcyl = w_cyl;
                n_known  = 1'b1;
                n_dst    = fts_pkg::DRV_SEEK;
                n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_SEEK,
                    w_cyl, w_head, 6'd0, 1'b0, 16'd0, 18'd0);
                cnt = cnt + 3'd1;
                n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_ARM,
                    8'd0, 1'b0, 6'd0, 1'b0, fts_pkg::T_SEEK_MS, 18'd0);
                cnt = cnt + 3'd1;
            end
        end

        // Start a sector transfer.
        if (do_xfer) begin
            n_dst = fts_pkg::DRV_XFER;
            n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_XFER,
                w_cyl, w_head, w_sec, n_reqwr, 16'd0, 18'd0);
            cnt = cnt + 3'd1;
            n_res[cnt[1:0]] = fts_pkg::mk_res(fts_pkg::ACT_ARM,
                8'd0, 1'b0, 6'd0, 1'b0, fts_pkg::T_RESET_MS, 18'd0);
            cnt = cnt + 3'd1;
        end

        n_cnt = cnt;
    end

    // Drive state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst    <= fts_pkg::DRV_CLOSED;
            r_armcyl <= 8'd0;
            r_known  <= 1'b0;
            r_err    <= 8'd0;
            r_active <= 1'b0;
            r_cur    <= 12'd0;
            r_left   <= 9'd0;
            r_done   <= 9'd0;
            r_reqwr  <= 1'b0;
            r_motor  <= 1'b0;
        end else if (r_seq == fts_pkg::SEQ_EXEC) begin
            r_dst    <= n_dst;
            r_armcyl <= n_armcyl;
            r_known  <= n_known;
            r_err    <= n_err;
            r_active <= n_active;
            r_cur    <= n_cur;
            r_left   <= n_left;
            r_done   <= n_done;
            r_reqwr  <= n_reqwr;
            r_motor  <= n_motor;
        end
    end

    // Result queue payload.
    always_ff @(posedge i_clk) begin
        if (r_seq == fts_pkg::SEQ_EXEC) begin
            for (int k = 0; k < 4; k++) begin
                r_res[k] <= n_res[k];
            end
        end
    end

    assign o_m_axis_tdata = {2'b00, r_res[r_idx]};
    assign o_m_axis_tlast = w_out_last;

endmodule

[rtl/fts_chk.sv]
// ----------------------------------------------------------------------------
// fts_chk
// Port-level checks of the floppy transfer sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module fts_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [55:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // A stalled action transaction holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("action payload changed while stalled");

    // No new event is taken while actions are still pending.
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("event taken while actions pending");

    // After the last action the block is ready for the next event.
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast |=>
        o_s_axis_tready && !o_m_axis_tvalid)
        else $error("not ready after last action");

    // Action codes stay within the defined set.
    a_action_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[3:0] <= 4'd10))
        else $error("undefined action code");

endmodule

bind floppy_transfer_sequencer_top fts_chk u_fts_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

[bench/tb_floppy_transfer_sequencer_top.sv]
// ----------------------------------------------------------------------------
// tb_floppy_transfer_sequencer_top
// Self-checking bench for the floppy transfer sequencer. A scoreboard
// predicts the action transactions of every accepted event and compares
// them with the action stream. Events are mostly sequences that walk a
// request through spin-up, recalibrate, seek, settle and transfers, under
// several register settings and random idling on both streams.
// ----------------------------------------------------------------------------

// Expected action transaction with its last flag.
typedef struct {
    fts_pkg::t_res res;
    logic          last;
} t_exp_action;

// Predicts the drive sequencer and checks its action transactions.
class seq_scoreboard;
    // Register copies.
    logic [5:0]    spt;
    logic [7:0]    gap_len;
    logic [7:0]    max_err;
    logic [15:0]   spinup_ms;
    logic [15:0]   settle_ms;
    logic [1:0]    drive_num;
    // Drive state.
    fts_pkg::t_drv drv;
    int unsigned   arm_cyl;
    bit            pos_known;
    int unsigned   err_cnt;
    bit            req_act;
    int unsigned   cur_blk;
    int unsigned   left_cnt;
    int unsigned   done_cnt;
    bit            req_wr;
    bit            motor;
    // Expected actions, oldest first.
    t_exp_action   pending_actions[$];
    fts_pkg::t_res staged[$];
    int            mismatches;

    function void reset_state();
        spt = 6'd18; gap_len = fts_pkg::GAP_DEFAULT; max_err = 8'd4;
        spinup_ms = 16'd1000; settle_ms = 16'd25; drive_num = 2'd0;
        drv = fts_pkg::DRV_CLOSED; arm_cyl = 0; pos_known = 1'b0; err_cnt = 0;
        req_act = 1'b0; cur_blk = 0; left_cnt = 0; done_cnt = 0;
        req_wr = 1'b0; motor = 1'b0;
        mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            fts_pkg::REG_SPT:    spt = val[5:0];
            fts_pkg::REG_GAP:    gap_len = val[7:0];
            fts_pkg::REG_MAXERR: max_err = val[7:0];
            fts_pkg::REG_SPINUP: spinup_ms = val[15:0];
            fts_pkg::REG_SETTLE: settle_ms = val[15:0];
            fts_pkg::REG_DRIVE:  drive_num = val[1:0];
            default: ;
        endcase
    endfunction

    function int unsigned spt_eff();
        return (spt == 0) ? 1 : spt;
    endfunction

    function int unsigned cyl_of(int unsigned b);
        int unsigned c;
        c = b / (2 * spt_eff());
        return (c > 255) ? 255 : c;
    endfunction

    function int unsigned head_of(int unsigned b);
        return (b % (2 * spt_eff())) / spt_eff();
    endfunction

    function void add(fts_pkg::t_act act, int unsigned cyl, int unsigned hd,
                      int unsigned sec, int unsigned wr, int unsigned ms,
                      int unsigned bytes);
        fts_pkg::t_res r;
        if (staged.size() >= 4) return;
        r.action = act;
        r.cylinder = cyl[7:0];
        r.head = hd[0];
        r.sector = sec[5:0];
        r.write_op = wr[0];
        r.timer_ms = ms[15:0];
        r.bytes_done = bytes[17:0];
        staged.push_back(r);
    endfunction

    function void bump_errors();
        if (err_cnt < 255) err_cnt++;
    endfunction

    function void fail_req();
        req_act = 1'b0;
        add(fts_pkg::ACT_FAILED, 0, 0, 0, 0, 0, 0);
    endfunction

    function void start_xfer();
        drv = fts_pkg::DRV_XFER;
        add(fts_pkg::ACT_XFER, cyl_of(cur_blk), head_of(cur_blk),
            cur_blk % spt_eff() + 1, req_wr, 0, 0);
        add(fts_pkg::ACT_ARM, 0, 0, 0, 0, fts_pkg::T_RESET_MS, 0);
    endfunction

    function void start_recal();
        pos_known = 1'b0;
        drv = fts_pkg::DRV_RECAL;
        add(fts_pkg::ACT_RECAL, 0, 0, 0, 0, 0, 0);
        add(fts_pkg::ACT_ARM, 0, 0, 0, 0, fts_pkg::T_RECAL_MS, 0);
    endfunction

    function void start_reset(bit count_err);
        if (count_err) bump_errors();
        drv = fts_pkg::DRV_RESET;
        add(fts_pkg::ACT_RESET, 0, 0, 0, 0, 0, 0);
        add(fts_pkg::ACT_ARM, 0, 0, 0, 0, fts_pkg::T_RESET_MS, 0);
    endfunction

    function void start_spinup(fts_pkg::t_drv nxt);
        motor = 1'b1;
        drv = nxt;
        add(fts_pkg::ACT_MOTOR_ON, 0, 0, 0, 0, 0, 0);
        add(fts_pkg::ACT_ARM, 0, 0, 0, 0, spinup_ms, 0);
    endfunction

    function void start_seek();
        int unsigned c;
        c = cyl_of(cur_blk);
        // Too many errors: give up on the request and stop the motor.
        if (err_cnt > max_err) begin
            err_cnt = 0;
            motor = 1'b0;
            drv = fts_pkg::DRV_CLOSED;
            add(fts_pkg::ACT_MOTOR_OFF, 0, 0, 0, 0, 0, 0);
            fail_req();
            return;
        end
        // Head already over the right cylinder: no seek needed.
        if (pos_known && arm_cyl == c) begin
            start_xfer();
            return;
        end
        add(fts_pkg::ACT_SEEK, c, head_of(cur_blk), 0, 0, 0, 0);
        arm_cyl = c;
        pos_known = 1'b1;
        drv = fts_pkg::DRV_SEEK;
        add(fts_pkg::ACT_ARM, 0, 0, 0, 0, fts_pkg::T_SEEK_MS, 0);
    endfunction

    function void sector_finished(logic [7:0] st0);
        int unsigned bytes;
        add(fts_pkg::ACT_CANCEL, 0, 0, 0, 0, 0, 0);
        if ((st0 & fts_pkg::ST0_ERR_MASK) != 0) begin
            bump_errors();
            start_recal();
            return;
        end
        err_cnt = 0;
        done_cnt = (done_cnt + 1) & 9'h1FF;
        cur_blk = (cur_blk + 1) & 12'hFFF;
        left_cnt = (left_cnt != 0) ? left_cnt - 1 : 0;
        if (left_cnt > 0) begin
            start_xfer();
            return;
        end
        bytes = done_cnt * 512;
        if (bytes > 262143) bytes = 262143;
        req_act = 1'b0;
        drv = fts_pkg::DRV_READY;
        add(fts_pkg::ACT_DONE, 0, 0, 0, 0, 0, bytes);
        add(fts_pkg::ACT_ARM, 0, 0, 0, 0, fts_pkg::T_IDLE_MS, 0);
    endfunction

    function void new_request(int unsigned blk, int unsigned cnt, bit wr);
        int unsigned last_blk;
        if (req_act) return;
        last_blk = blk + cnt - 1;
        if (drv == fts_pkg::DRV_ABSENT || cnt == 0 || cnt > 256 || last_blk > 4095 ||
            last_blk / (2 * spt_eff()) > 255) begin
            add(fts_pkg::ACT_FAILED, 0, 0, 0, 0, 0, 0);
            return;
        end
        req_act = 1'b1;
        cur_blk = blk;
        left_cnt = cnt;
        done_cnt = 0;
        req_wr = wr;
        if (drv == fts_pkg::DRV_READY) start_seek();
        else if (drv == fts_pkg::DRV_OFF) start_spinup(fts_pkg::DRV_SPINUP_WARM);
        else start_spinup(fts_pkg::DRV_SPINUP);
    endfunction

    // Works out the actions of one accepted event and queues them.
    function void predict_actions(logic [1:0] kind, logic [11:0] blk, logic [8:0] cnt,
                                  logic wr, logic [7:0] st0);
        t_exp_action e;
        staged.delete();
        if (kind == fts_pkg::KIND_WORK) begin
            new_request(blk, cnt, wr);
        end else if (kind == fts_pkg::KIND_CLOSE) begin
            if (req_act) begin
                add(fts_pkg::ACT_CANCEL, 0, 0, 0, 0, 0, 0);
                fail_req();
                motor = 1'b0;
                drv = fts_pkg::DRV_CLOSED;
                add(fts_pkg::ACT_MOTOR_OFF, 0, 0, 0, 0, 0, 0);
            end else if (drv != fts_pkg::DRV_ABSENT) begin
                drv = fts_pkg::DRV_CLOSED;
                if (motor) begin
                    motor = 1'b0;
                    add(fts_pkg::ACT_MOTOR_OFF, 0, 0, 0, 0, 0, 0);
                end
            end
        end else if (!req_act) begin
            // Idle timer stops a running motor.
            if (kind == fts_pkg::KIND_TIMER && motor) begin
                motor = 1'b0;
                drv = fts_pkg::DRV_OFF;
                add(fts_pkg::ACT_MOTOR_OFF, 0, 0, 0, 0, 0, 0);
            end
        end else if (kind == fts_pkg::KIND_TIMER) begin
            case (drv)
                fts_pkg::DRV_SPINUP: start_reset(1'b0);
                fts_pkg::DRV_RESET: begin
                    drv = fts_pkg::DRV_ABSENT;
                    motor = 1'b0;
                    add(fts_pkg::ACT_MOTOR_OFF, 0, 0, 0, 0, 0, 0);
                    add(fts_pkg::ACT_DECONF, 0, 0, 0, 0, 0, 0);
                    fail_req();
                end
                fts_pkg::DRV_RECAL: begin
                    motor = 1'b0;
                    drv = fts_pkg::DRV_CLOSED;
                    add(fts_pkg::ACT_MOTOR_OFF, 0, 0, 0, 0, 0, 0);
                    fail_req();
                end
                fts_pkg::DRV_SEEK: start_reset(1'b0);
                fts_pkg::DRV_SETTLE: start_xfer();
                fts_pkg::DRV_XFER: start_reset(1'b1);
                fts_pkg::DRV_SPINUP_WARM: start_seek();
                default: ;
            endcase
        end else begin
            case (drv)
                fts_pkg::DRV_RESET: start_recal();
                fts_pkg::DRV_RECAL: start_seek();
                fts_pkg::DRV_SEEK: begin
                    drv = fts_pkg::DRV_SETTLE;
                    add(fts_pkg::ACT_ARM, 0, 0, 0, 0, settle_ms, 0);
                end
                fts_pkg::DRV_XFER: sector_finished(st0);
                default: ;
            endcase
        end
        foreach (staged[i]) begin
            e.res = staged[i];
            e.last = (i == staged.size() - 1);
            pending_actions.push_back(e);
        end
    endfunction

    // Compares one accepted action transaction with the oldest expectation.
    function void check_action(logic [55:0] data, logic last);
        fts_pkg::t_res got;
        t_exp_action e;
        got = fts_pkg::t_res'(data[53:0]);
        if (pending_actions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected action %0d (data %h last %0b)",
                         got.action, data, last);
            return;
        end
        e = pending_actions.pop_front();
        if (got != e.res || last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"Action mismatch: exp act %0d cyl %0d hd %0d sec %0d wr %0b",
                          " ms %0d bytes %0d last %0b, got act %0d cyl %0d hd %0d",
                          " sec %0d wr %0b ms %0d bytes %0d last %0b"},
                         e.res.action, e.res.cylinder, e.res.head, e.res.sector,
                         e.res.write_op, e.res.timer_ms, e.res.bytes_done, e.last,
                         got.action, got.cylinder, got.head, got.sector,
                         got.write_op, got.timer_ms, got.bytes_done, last);
        end
    endfunction
endclass

module tb_floppy_transfer_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_axis_tvalid = 0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 0;
    logic [55:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        i_psel = 0;
    logic        i_penable = 0;
    logic        i_pwrite = 0;
    logic [4:0]  i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    seq_scoreboard sb = new();
    bit            quiet_sender;
    bit            quiet_receiver;

    floppy_transfer_sequencer_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Run limit.
    initial begin
        #3ms;
        $display("Verification failed");
        $finish;
    end

    // Register write: setup cycle then access cycle.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_psel = 1'b1; i_pwrite = 1'b1; i_penable = 1'b0;
        i_paddr = {idx, 2'b00}; i_pwdata = val;
        @(negedge i_clk);
        i_penable = 1'b1;
        do @(posedge i_clk); while (!o_pready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_psel = 1'b0; i_penable = 1'b0; i_pwrite = 1'b0;
    endtask

    // Sends one event and notes it once the transaction is accepted.
    task automatic send_event(logic [1:0] kind, logic [11:0] blk, logic [8:0] cnt,
                              logic wr, logic [7:0] st0);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tuser = kind;
        i_s_axis_tdata = {2'b00, st0, wr, cnt, blk};
        i_s_axis_tvalid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready) break;
            @(negedge i_clk);
        end
        sb.predict_actions(kind, blk, cnt, wr, st0);
        @(negedge i_clk);
    endtask

    // Waits until every expected action has come and the block has settled.
    task automatic wait_drained();
        i_s_axis_tvalid = 1'b0;
        while (sb.pending_actions.size() > 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Picks the next event, mostly the one that moves the request along.
    task automatic random_event();
        int r;
        int unsigned lim;
        logic [1:0] kind;
        logic [11:0] blk;
        logic [8:0] cnt;
        logic [7:0] st0;
        r = $urandom_range(0, 99);
        st0 = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) >= 15) st0 = st0 & 8'h07;
        cnt = ($urandom_range(0, 99) < 6) ? 9'($urandom_range(0, 511))
                                          : 9'($urandom_range(1, 5));
        lim = 512 * sb.spt_eff();
        lim = (lim > 4096) ? 4096 : lim;
        if ($urandom_range(0, 99) < 8 || cnt == 0 || cnt > lim)
            blk = 12'($urandom_range(0, 4095));
        else
            blk = 12'($urandom_range(0, lim - cnt));
        if (!sb.req_act) begin
            if (r < 75) kind = fts_pkg::KIND_WORK;
            else if (r < 88) kind = fts_pkg::KIND_TIMER;
            else if (r < 95) kind = fts_pkg::KIND_CLOSE;
            else kind = fts_pkg::KIND_IRQ;
        end else if (r < 8) begin
            kind = 2'($urandom_range(0, 3));
        end else begin
            case (sb.drv)
                fts_pkg::DRV_RESET, fts_pkg::DRV_SEEK, fts_pkg::DRV_RECAL:
                    kind = (r < 13) ? fts_pkg::KIND_TIMER : fts_pkg::KIND_IRQ;
                fts_pkg::DRV_XFER:
                    kind = (r < 12) ? fts_pkg::KIND_TIMER : fts_pkg::KIND_IRQ;
                default: kind = fts_pkg::KIND_TIMER;
            endcase
        end
        // A timer during reset marks the drive absent for good; kept for the end.
        if (sb.req_act && sb.drv == fts_pkg::DRV_RESET && kind == fts_pkg::KIND_TIMER)
            kind = fts_pkg::KIND_IRQ;
        send_event(kind, blk, cnt, 1'($urandom_range(0, 1)), st0);
    endtask

    // Action stream: random stalls, checking at each accepted transaction.
    initial begin
        int stall;
        int burst;
        burst = 0;
        @(posedge i_rst_n);
        forever begin
            if (burst == 0) begin
                quiet_receiver = ($urandom_range(0, 3) == 0);
                burst = $urandom_range(8, 32);
            end
            burst--;
            stall = quiet_receiver ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            forever begin
                @(posedge i_clk);
                if (o_m_axis_tvalid) begin
                    sb.check_action(o_m_axis_tdata, o_m_axis_tlast);
                    break;
                end
            end
            @(negedge i_clk);
        end
    end

    // Main stimulus.
    initial begin
        int n;
        sb.reset_state();
        quiet_sender = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (4) @(negedge i_clk);

        // Directed: idle events, bad requests, a full request with a retry.
        send_event(fts_pkg::KIND_CLOSE, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_TIMER, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_IRQ, '0, '0, 1'b0, 8'hFF);
        send_event(fts_pkg::KIND_WORK, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_WORK, '0, 9'd257, 1'b1, '0);
        send_event(fts_pkg::KIND_WORK, 12'd4095, 9'd2, 1'b0, '0);
        send_event(fts_pkg::KIND_WORK, 12'd4095, 9'd1, 1'b1, '0);
        send_event(fts_pkg::KIND_TIMER, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_IRQ, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_IRQ, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_WORK, 12'd5, 9'd1, 1'b0, '0);
        send_event(fts_pkg::KIND_IRQ, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_TIMER, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_IRQ, '0, '0, 1'b0, 8'h08);
        send_event(fts_pkg::KIND_IRQ, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_IRQ, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_TIMER, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_IRQ, '0, '0, 1'b0, 8'h07);
        send_event(fts_pkg::KIND_WORK, 12'd4094, 9'd256 - 9'd255, 1'b0, '0);
        send_event(fts_pkg::KIND_IRQ, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_TIMER, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_WORK, 12'd100, 9'd2, 1'b1, '0);
        send_event(fts_pkg::KIND_CLOSE, '0, '0, 1'b0, '0);
        wait_drained();

        // Random phases under different settings.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin
                    write_reg(fts_pkg::REG_SPT, 32'd63);
                    write_reg(fts_pkg::REG_GAP, 32'd255);
                    write_reg(fts_pkg::REG_MAXERR, 32'd0);
                    write_reg(fts_pkg::REG_SPINUP, 32'd65535);
                    write_reg(fts_pkg::REG_SETTLE, 32'd0);
                    write_reg(fts_pkg::REG_DRIVE, 32'd3);
                end
                2: begin
                    write_reg(fts_pkg::REG_SPT, 32'd0);
                    write_reg(fts_pkg::REG_GAP, 32'd0);
                    write_reg(fts_pkg::REG_MAXERR, 32'd255);
                    write_reg(fts_pkg::REG_SPINUP, 32'd0);
                    write_reg(fts_pkg::REG_SETTLE, 32'd65535);
                    write_reg(fts_pkg::REG_DRIVE, 32'd0);
                end
                3: begin
                    write_reg(fts_pkg::REG_SPT, 32'd1);
                    write_reg(fts_pkg::REG_MAXERR, 32'd1);
                    write_reg(fts_pkg::REG_SPINUP, $urandom_range(0, 65535));
                    write_reg(fts_pkg::REG_SETTLE, $urandom_range(0, 65535));
                end
                4: begin
                    write_reg(fts_pkg::REG_SPT, 32'd15);
                    write_reg(fts_pkg::REG_MAXERR, 32'd2);
                    write_reg(fts_pkg::REG_GAP, $urandom_range(0, 255));
                    write_reg(fts_pkg::REG_DRIVE, $urandom_range(0, 3));
                end
                default: ;
            endcase
            n = 0;
            while (n < 28) begin
                if (n % 12 == 0) quiet_sender = ($urandom_range(0, 3) == 0);
                random_event();
                n++;
                // Hold off once until the block has caught up.
                if (ph == 1 && n == 10) wait_drained();
            end
            wait_drained();
        end

        // Absent drive: reset timeout, then requests fail and close keeps it absent.
        quiet_sender = 1'b0;
        send_event(fts_pkg::KIND_CLOSE, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_WORK, 12'd7, 9'd1, 1'b0, '0);
        send_event(fts_pkg::KIND_TIMER, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_TIMER, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_WORK, 12'd7, 9'd1, 1'b0, '0);
        send_event(fts_pkg::KIND_CLOSE, '0, '0, 1'b0, '0);
        send_event(fts_pkg::KIND_WORK, 12'd9, 9'd3, 1'b1, '0);
        i_s_axis_tvalid = 1'b0;

        // Drain and finish.
        n = 0;
        while (sb.pending_actions.size() > 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (64) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_actions.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/fts_pkg.sv
rtl/fts_div.sv
rtl/floppy_transfer_sequencer_top.sv
rtl/fts_chk.sv
bench/tb_floppy_transfer_sequencer_top.sv
